// File: hw/rtl/slbc_pkg.sv
package slbc_pkg;

    localparam int POS_BITS   = 24;
    localparam int DEPTH_BITS = 16;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    // Lexer states, one-hot
    typedef enum logic [5:0] {
        ST_NONE    = 6'b000001,
        ST_COMMENT = 6'b000010,
        ST_IDENT   = 6'b000100,
        ST_NUMBER  = 6'b001000,
        ST_DQUOTE  = 6'b010000,
        ST_SQUOTE  = 6'b100000
    } t_lex;

    // Token kinds
    localparam logic [3:0] TK_COMMENT      = 4'd0;
    localparam logic [3:0] TK_IDENT        = 4'd1;
    localparam logic [3:0] TK_NUMBER       = 4'd2;
    localparam logic [3:0] TK_DQUOTE       = 4'd3;
    localparam logic [3:0] TK_SQUOTE       = 4'd4;
    localparam logic [3:0] TK_PAREN_OPEN   = 4'd5;
    localparam logic [3:0] TK_PAREN_CLOSE  = 4'd6;
    localparam logic [3:0] TK_CURLY_OPEN   = 4'd7;
    localparam logic [3:0] TK_CURLY_CLOSE  = 4'd8;
    localparam logic [3:0] TK_SQUARE_OPEN  = 4'd9;
    localparam logic [3:0] TK_SQUARE_CLOSE = 4'd10;
    localparam logic [3:0] TK_COMMA        = 4'd11;

    // Error codes
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_LIT         = 3'd1;
    localparam logic [2:0] ERR_CLOSE_PAREN = 3'd2;
    localparam logic [2:0] ERR_OPEN_PAREN  = 3'd5;

    // Character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LCUR   = 8'h7B;
    localparam logic [7:0] CH_RCUR   = 8'h7D;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef logic [POS_BITS-1:0]   t_pos;
    typedef logic [DEPTH_BITS-1:0] t_depth;

    // Bracket tracking and latched error
    typedef struct packed {
        t_depth [2:0] depth;
        logic   [2:0] open_vld;
        t_pos   [2:0] open_line;
        logic   [2:0] err;
        t_pos         err_line;
        t_pos         err_ls;
        t_pos         err_pos;
    } t_brk;

    // One result item
    typedef struct packed {
        logic       rec_kind;
        logic [3:0] token_kind;
        t_pos       line_number;
        t_pos       line_start_pos;
        t_pos       start_pos;
        t_pos       token_length;
        logic [2:0] error_code;
        logic       last_result;
    } t_res;

    function automatic logic f_is_op(logic [7:0] c);
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2D, 8'h3B, 8'h3A,
            8'h2E, 8'h2F, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5C, 8'h5E, 8'h7E,
            8'h7C:   return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic f_is_sep(logic [7:0] c);
        case (c)
            CH_LSQ, CH_RSQ, CH_LCUR, CH_RCUR, CH_LPAR, CH_RPAR, CH_COMMA,
            CH_COLON: return 1'b1;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic logic [3:0] f_lex_kind(t_lex s);
        unique case (s)
            ST_COMMENT: return TK_COMMENT;
            ST_IDENT:   return TK_IDENT;
            ST_NUMBER:  return TK_NUMBER;
            ST_DQUOTE:  return TK_DQUOTE;
            ST_SQUOTE:  return TK_SQUOTE;
            default:    return TK_COMMENT;
        endcase
    endfunction

    // Apply one delivered token to the bracket tracking
    function automatic t_brk f_brk(t_brk b, logic vld, logic [3:0] kind, t_pos start,
                                   t_pos line, t_pos ls);
        t_brk       r;
        logic [3:0] off;
        logic [1:0] idx;
        r   = b;
        off = kind - TK_PAREN_OPEN;
        idx = off[2:1];
        if (vld && b.err == ERR_OK && kind >= TK_PAREN_OPEN && kind <= TK_SQUARE_CLOSE) begin
            if (!off[0]) begin
                if (r.depth[idx] != DEPTH_MAX) r.depth[idx] = r.depth[idx] + 1'b1;
                if (!r.open_vld[idx]) begin
                    r.open_vld[idx]  = 1'b1;
                    r.open_line[idx] = line;
                end
            end else if (r.depth[idx] == '0) begin
                r.err      = ERR_CLOSE_PAREN + {1'b0, idx};
                r.err_line = line;
                r.err_ls   = ls;
                r.err_pos  = start;
            end else begin
                r.depth[idx] = r.depth[idx] - 1'b1;
                if (r.depth[idx] == '0) r.open_vld[idx] = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/source_lexer_bracket_check_core.sv
// Streaming lexer with bracket balance check. One source byte is taken per
// cycle while o_stall is low; each byte yields zero to two token items, and
// the byte flagged last adds one status item and returns the lexer state to
// its reset values for the next source. All lexing of a byte is done in the
// cycle it is taken and its items are held in a four-slot result register
// that drains one item per cycle while i_stall is low. A byte that makes at
// most one item lets the next byte in the next cycle if that item is taken;
// more items (up to three, status included) stall input until the last pops.
// A line break inside a literal latches error 1 and the rest of the source is
// ignored up to the last byte; tokens sent before it are to be discarded.
module source_lexer_bracket_check_core
    import slbc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_src_byte,
    input  logic             i_is_last,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_rec_kind,
    output logic [3:0]       o_token_kind,
    output logic [POS_BITS-1:0] o_line_number,
    output logic [POS_BITS-1:0] o_line_start_pos,
    output logic [POS_BITS-1:0] o_start_pos,
    output logic [POS_BITS-1:0] o_token_length,
    output logic [2:0]       o_error_code,
    output logic             o_last_result
);

    logic       r_keep;
    t_lex       r_st, n_st;
    logic [7:0] r_prev, n_prev;
    logic       r_ps, n_ps;
    t_pos       r_pos, n_pos;
    t_pos       r_tks, n_tks;
    t_pos       r_line, n_line;
    t_pos       r_ls, n_ls;
    t_brk       r_brk, n_brk;
    logic       r_halted, n_halted;
    logic [1:0] r_head, n_head;

    t_res       r_slot [4];
    t_res       n_slot [4];
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_rd;

    logic accept, pop, free;

    assign pop    = o_valid && !i_stall;
    assign free   = (r_cnt == 3'd0) || (r_cnt == 3'd1 && pop);
    assign accept = i_valid && free;

    assign o_stall = !free;
    assign o_valid = (r_cnt != 3'd0);

    assign o_rec_kind       = r_slot[r_rd].rec_kind;
    assign o_token_kind     = r_slot[r_rd].token_kind;
    assign o_line_number    = r_slot[r_rd].line_number;
    assign o_line_start_pos = r_slot[r_rd].line_start_pos;
    assign o_start_pos      = r_slot[r_rd].start_pos;
    assign o_token_length   = r_slot[r_rd].token_length;
    assign o_error_code     = r_slot[r_rd].error_code;
    assign o_last_result    = r_slot[r_rd].last_result;

    // Lex one byte: work out the next state and the items it makes
    always_comb begin
        t_lex       st;
        logic       do_disp;
        logic       is_op_c, is_op_p, boundary;
        logic [7:0] c;
        logic       [2:0] d_vld;
        logic [2:0][3:0]  d_kind;
        t_pos [2:0]       d_start;
        t_pos [2:0]       d_len;
        t_brk       b1, b2;
        logic [2:0] code;
        t_pos       s_line, s_ls, s_sp;
        logic [2:0] k;

        c        = i_src_byte;
        n_st     = r_st;
        n_prev   = r_prev;
        n_ps     = r_ps;
        n_pos    = r_pos;
        n_tks    = r_tks;
        n_line   = r_line;
        n_ls     = r_ls;
        n_halted = r_halted;
        n_head   = r_head;
        st       = r_st;
        do_disp  = 1'b0;
        d_vld    = '0;
        d_kind   = '0;
        d_start  = '0;
        d_len    = '0;
        is_op_c  = f_is_op(c);
        is_op_p  = f_is_op(r_prev);
        boundary = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_DQ) || (c == CH_SQ) ||
                   f_is_sep(c) || (is_op_c && !is_op_p) || (is_op_p && !is_op_c);

        if (!r_halted) begin
            if (r_head == 2'd1 && r_prev == CH_HASH && r_st == ST_IDENT && c == CH_BANG &&
                !i_is_last) begin
                n_st = ST_COMMENT;
            end else if (r_ps && c == CH_SLASH) begin
                n_ps = 1'b0;
                n_st = ST_COMMENT;
            end else begin
                if (r_ps) begin
                    n_ps = 1'b0;
                    st   = ST_IDENT;
                end
                n_st = st;
                if (c == CH_NL) begin
                    if (st == ST_DQUOTE || st == ST_SQUOTE) begin
                        n_halted = 1'b1;
                    end else begin
                        if (st != ST_NONE) begin
                            d_vld[0]   = 1'b1;
                            d_kind[0]  = f_lex_kind(st);
                            d_start[0] = r_tks;
                            d_len[0]   = r_pos - r_tks;
                        end
                        n_st   = ST_NONE;
                        n_line = r_line + 1'b1;
                        n_ls   = r_pos + 1'b1;
                    end
                end else begin
                    unique case (st)
                        ST_IDENT, ST_NUMBER: begin
                            if (boundary) begin
                                d_vld[0]   = 1'b1;
                                d_kind[0]  = f_lex_kind(st);
                                d_start[0] = r_tks;
                                d_len[0]   = r_pos - r_tks;
                                n_st       = ST_NONE;
                                do_disp    = 1'b1;
                            end
                        end
                        ST_DQUOTE, ST_SQUOTE: begin
                            if (c == ((st == ST_DQUOTE) ? CH_DQ : CH_SQ) &&
                                r_prev != CH_BSLASH) begin
                                d_vld[0]   = 1'b1;
                                d_kind[0]  = f_lex_kind(st);
                                d_start[0] = r_tks;
                                d_len[0]   = r_pos - r_tks + 1'b1;
                                n_st       = ST_NONE;
                            end
                        end
                        ST_COMMENT: ;
                        default: do_disp = 1'b1;
                    endcase
                end

                // Start a token from the idle state
                if (do_disp) begin
                    d_start[1] = r_pos;
                    d_len[1]   = t_pos'(1);
                    case (c)
                        CH_DQ:    begin n_tks = r_pos; n_st = ST_DQUOTE; end
                        CH_SQ:    begin n_tks = r_pos; n_st = ST_SQUOTE; end
                        CH_LPAR:  begin d_vld[1] = 1'b1; d_kind[1] = TK_PAREN_OPEN;   end
                        CH_RPAR:  begin d_vld[1] = 1'b1; d_kind[1] = TK_PAREN_CLOSE;  end
                        CH_LCUR:  begin d_vld[1] = 1'b1; d_kind[1] = TK_CURLY_OPEN;   end
                        CH_RCUR:  begin d_vld[1] = 1'b1; d_kind[1] = TK_CURLY_CLOSE;  end
                        CH_LSQ:   begin d_vld[1] = 1'b1; d_kind[1] = TK_SQUARE_OPEN;  end
                        CH_RSQ:   begin d_vld[1] = 1'b1; d_kind[1] = TK_SQUARE_CLOSE; end
                        CH_COMMA: begin d_vld[1] = 1'b1; d_kind[1] = TK_COMMA;        end
                        CH_SPACE, CH_TAB: ;
                        CH_SLASH: begin
                            n_tks = r_pos;
                            if (i_is_last) n_st = ST_IDENT;
                            else           n_ps = 1'b1;
                        end
                        default: begin
                            n_tks = r_pos;
                            n_st  = (c >= CH_ZERO && c <= CH_NINE) ? ST_NUMBER : ST_IDENT;
                        end
                    endcase
                end
            end
        end

        // Flush the open token on the last byte
        if (i_is_last && !n_halted && n_st != ST_NONE) begin
            d_vld[2]   = 1'b1;
            d_kind[2]  = f_lex_kind(n_st);
            d_start[2] = n_tks;
            d_len[2]   = r_pos + 1'b1 - n_tks;
        end

        // Chain the bracket tracking through the delivered tokens
        b1 = f_brk(r_brk, d_vld[0], d_kind[0], d_start[0], r_line, r_ls);
        b2 = f_brk(b1, d_vld[1], d_kind[1], d_start[1], r_line, r_ls);
        if (n_halted && !r_halted) begin
            b2.err      = ERR_LIT;
            b2.err_line = r_line;
            b2.err_ls   = r_ls;
            b2.err_pos  = r_tks;
        end
        n_brk = f_brk(b2, d_vld[2], d_kind[2], d_start[2], r_line, r_ls);

        // Pack the items in order, dropping comments unless kept
        for (int i = 0; i < 4; i++) n_slot[i] = r_slot[i];
        k = 3'd0;
        for (int i = 0; i < 3; i++) begin
            if (d_vld[i] && (d_kind[i] != TK_COMMENT || r_keep)) begin
                n_slot[k[1:0]].rec_kind       = 1'b0;
                n_slot[k[1:0]].token_kind     = d_kind[i];
                n_slot[k[1:0]].line_number    = r_line;
                n_slot[k[1:0]].line_start_pos = r_ls;
                n_slot[k[1:0]].start_pos      = d_start[i];
                n_slot[k[1:0]].token_length   = d_len[i];
                n_slot[k[1:0]].error_code     = ERR_OK;
                n_slot[k[1:0]].last_result    = 1'b0;
                k = k + 3'd1;
            end
        end

        // Status item and return to reset on the last byte
        code   = n_brk.err;
        s_line = n_brk.err_line;
        s_ls   = n_brk.err_ls;
        s_sp   = n_brk.err_pos;
        if (code == ERR_OK) begin
            if (n_brk.depth[0] != '0) begin
                code = ERR_OPEN_PAREN;        s_line = n_brk.open_line[0];
                s_ls = '0; s_sp = '0;
            end else if (n_brk.depth[1] != '0) begin
                code = ERR_OPEN_PAREN + 3'd1; s_line = n_brk.open_line[1];
                s_ls = '0; s_sp = '0;
            end else if (n_brk.depth[2] != '0) begin
                code = ERR_OPEN_PAREN + 3'd2; s_line = n_brk.open_line[2];
                s_ls = '0; s_sp = '0;
            end
        end
        if (i_is_last) begin
            n_slot[k[1:0]].rec_kind       = 1'b1;
            n_slot[k[1:0]].token_kind     = TK_COMMENT;
            n_slot[k[1:0]].line_number    = s_line;
            n_slot[k[1:0]].line_start_pos = s_ls;
            n_slot[k[1:0]].start_pos      = s_sp;
            n_slot[k[1:0]].token_length   = '0;
            n_slot[k[1:0]].error_code     = code;
            n_slot[k[1:0]].last_result    = 1'b1;
            k = k + 3'd1;
            n_st     = ST_NONE;
            n_prev   = '0;
            n_ps     = 1'b0;
            n_pos    = '0;
            n_tks    = '0;
            n_line   = '0;
            n_ls     = '0;
            n_brk    = '0;
            n_halted = 1'b0;
            n_head   = 2'd0;
        end else begin
            n_prev = c;
            n_pos  = r_pos + 1'b1;
            if (r_head != 2'd2) n_head = r_head + 2'd1;
        end
        n_cnt = k;
    end

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_keep <= 1'b0;
        else if (i_cfg_we) r_keep <= i_cfg_wdata;
    end

    // Advance the lexer state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_NONE;
            r_prev   <= '0;
            r_ps     <= 1'b0;
            r_pos    <= '0;
            r_tks    <= '0;
            r_line   <= '0;
            r_ls     <= '0;
            r_brk    <= '0;
            r_halted <= 1'b0;
            r_head   <= 2'd0;
        end else if (accept) begin
            r_st     <= n_st;
            r_prev   <= n_prev;
            r_ps     <= n_ps;
            r_pos    <= n_pos;
            r_tks    <= n_tks;
            r_line   <= n_line;
            r_ls     <= n_ls;
            r_brk    <= n_brk;
            r_halted <= n_halted;
            r_head   <= n_head;
        end
    end

    // Load the result slots and drain them one per cycle while i_stall is low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_rd  <= 2'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_rd  <= 2'd0;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
            r_rd  <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 4; i++) r_slot[i] <= n_slot[i];
        end
    end

    a_halt_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_brk.err == ERR_LIT)
        else $error("halted without literal error");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_result) |-> r_cnt == 3'd1)
        else $error("status item not last of its byte");

    a_slash_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ps |-> r_st == ST_NONE)
        else $error("pending slash outside idle state");

endmodule

// File: sim/source_lexer_bracket_check_core_tb.sv
`timescale 1ns / 1ps

module source_lexer_bracket_check_core_tb;
    import slbc_pkg::*;

    // Lexer state codes used by the predictor
    typedef enum logic [2:0] {
        LX_NONE, LX_COMMENT, LX_IDENT, LX_NUMBER, LX_DQUOTE, LX_SQUOTE
    } t_lx;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_wdata;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_src_byte;
    logic             i_is_last;
    logic             o_valid;
    logic             i_stall;
    logic             o_rec_kind;
    logic [3:0]       o_token_kind;
    logic [POS_BITS-1:0] o_line_number;
    logic [POS_BITS-1:0] o_line_start_pos;
    logic [POS_BITS-1:0] o_start_pos;
    logic [POS_BITS-1:0] o_token_length;
    logic [2:0]       o_error_code;
    logic             o_last_result;

    source_lexer_bracket_check_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_src_byte(i_src_byte), .i_is_last(i_is_last),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_rec_kind(o_rec_kind), .o_token_kind(o_token_kind),
        .o_line_number(o_line_number), .o_line_start_pos(o_line_start_pos),
        .o_start_pos(o_start_pos), .o_token_length(o_token_length),
        .o_error_code(o_error_code), .o_last_result(o_last_result)
    );

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // Predictor state
    logic        keep_cmt;
    t_lx         lx;
    logic [7:0]  prv;
    logic        slash_wait;
    t_pos        bpos, tstart, line, line_st;
    t_depth      depth [3];
    logic        open_vld [3];
    t_pos        open_line [3];
    logic [2:0]  err;
    logic        halted;
    int          head;
    t_pos        e_line, e_ls, e_pos;

    t_res        tok_queue [$];
    int          n_fail;
    int          n_tok, n_status;
    logic        out_random;

    function automatic logic is_op(logic [7:0] c);
        case (c)
            "!", "#", "$", "&", "*", "+", "-", ";", ":", ".", "/", "<", "=",
            ">", "?", "@", "\\", "^", "~", "|", "%": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_sep(logic [7:0] c);
        case (c)
            "[", "]", "{", "}", "(", ")", ",", ":": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic clear_stream();
        lx = LX_NONE; prv = '0; slash_wait = 1'b0; bpos = '0; tstart = '0;
        line = '0; line_st = '0; err = ERR_OK; halted = 1'b0; head = 0;
        e_line = '0; e_ls = '0; e_pos = '0;
        for (int k = 0; k < 3; k++) begin
            depth[k] = '0; open_vld[k] = 1'b0; open_line[k] = '0;
        end
    endtask

    // Queue one token and track bracket balance
    task automatic emit_token(logic [3:0] kind, t_pos st, t_pos len);
        t_res r;
        int   idx;
        if (kind == TK_COMMENT && !keep_cmt) return;
        r = '0;
        r.token_kind = kind; r.line_number = line; r.line_start_pos = line_st;
        r.start_pos = st; r.token_length = len;
        tok_queue.push_back(r);
        if (err != ERR_OK || kind < TK_PAREN_OPEN || kind > TK_SQUARE_CLOSE) return;
        idx = (kind - TK_PAREN_OPEN) >> 1;
        if (((kind - TK_PAREN_OPEN) & 1) == 0) begin
            if (depth[idx] != DEPTH_MAX) depth[idx]++;
            if (!open_vld[idx]) begin
                open_vld[idx] = 1'b1; open_line[idx] = line;
            end
        end else if (depth[idx] == 0) begin
            err = 3'(ERR_CLOSE_PAREN + idx);
            e_line = line; e_ls = line_st; e_pos = st;
        end else begin
            depth[idx]--;
            if (depth[idx] == 0) open_vld[idx] = 1'b0;
        end
    endtask

    task automatic start_fresh(logic [7:0] c, t_pos p, logic last);
        case (c)
            "\"": begin tstart = p; lx = LX_DQUOTE; end
            "'":  begin tstart = p; lx = LX_SQUOTE; end
            "(":  emit_token(TK_PAREN_OPEN, p, t_pos'(1));
            ")":  emit_token(TK_PAREN_CLOSE, p, t_pos'(1));
            "{":  emit_token(TK_CURLY_OPEN, p, t_pos'(1));
            "}":  emit_token(TK_CURLY_CLOSE, p, t_pos'(1));
            "[":  emit_token(TK_SQUARE_OPEN, p, t_pos'(1));
            "]":  emit_token(TK_SQUARE_CLOSE, p, t_pos'(1));
            ",":  emit_token(TK_COMMA, p, t_pos'(1));
            " ", "\t": ;
            "/": begin
                tstart = p;
                if (last) lx = LX_IDENT;
                else slash_wait = 1'b1;
            end
            default: begin
                tstart = p;
                lx = (c >= "0" && c <= "9") ? LX_NUMBER : LX_IDENT;
            end
        endcase
    endtask

    task automatic lex_byte(logic [7:0] c, t_pos p, logic last);
        logic [7:0] q;
        if (c == CH_NL) begin
            if (lx == LX_DQUOTE || lx == LX_SQUOTE) begin
                err = ERR_LIT; e_line = line; e_ls = line_st; e_pos = tstart;
                halted = 1'b1;
                return;
            end
            if (lx != LX_NONE) begin
                emit_token(4'(lx - 1), tstart, p - tstart);
                lx = LX_NONE;
            end
            line = t_pos'(line + 1); line_st = t_pos'(p + 1);
            return;
        end
        case (lx)
            LX_IDENT, LX_NUMBER:
                if (c == " " || c == "\t" || c == "\"" || c == "'" || is_sep(c) ||
                    (is_op(c) && !is_op(prv)) || (is_op(prv) && !is_op(c))) begin
                    emit_token(4'(lx - 1), tstart, p - tstart);
                    lx = LX_NONE;
                    start_fresh(c, p, last);
                end
            LX_DQUOTE, LX_SQUOTE: begin
                q = (lx == LX_DQUOTE) ? CH_DQ : CH_SQ;
                if (c == q && prv != CH_BSLASH) begin
                    emit_token(4'(lx - 1), tstart, t_pos'(p - tstart + 1));
                    lx = LX_NONE;
                end
            end
            LX_COMMENT: ;
            default: start_fresh(c, p, last);
        endcase
    endtask

    // Work out the items caused by one accepted byte
    task automatic predict_byte(logic [7:0] c, logic last);
        t_pos p;
        t_res r;
        p = bpos;
        if (!halted) begin
            if (head == 1 && prv == CH_HASH && lx == LX_IDENT && c == CH_BANG && !last)
                lx = LX_COMMENT;
            else if (slash_wait && c == CH_SLASH) begin
                slash_wait = 1'b0; lx = LX_COMMENT;
            end else begin
                if (slash_wait) begin
                    slash_wait = 1'b0; lx = LX_IDENT;
                end
                lex_byte(c, p, last);
            end
        end
        if (last) begin
            if (!halted && lx != LX_NONE)
                emit_token(4'(lx - 1), tstart, t_pos'(p + 1 - tstart));
            r = '0;
            r.rec_kind = 1'b1; r.last_result = 1'b1; r.error_code = err;
            r.line_number = e_line; r.line_start_pos = e_ls; r.start_pos = e_pos;
            if (err == ERR_OK) begin
                for (int k = 0; k < 3; k++) begin
                    if (depth[k] != 0) begin
                        r.error_code = 3'(ERR_OPEN_PAREN + k);
                        r.line_number = open_line[k];
                        r.line_start_pos = '0; r.start_pos = '0;
                        break;
                    end
                end
            end
            tok_queue.push_back(r);
            clear_stream();
            return;
        end
        prv = c; bpos = t_pos'(p + 1);
        if (head < 2) head++;
    endtask

    // Send one request and predict its results
    task automatic send_byte(logic [7:0] c, logic last);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1; i_src_byte <= c; i_is_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(c, last);
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, logic last_at_end);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], last_at_end && k == s.len() - 1);
    endtask

    task automatic drain_wait();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (tok_queue.size() != 0 && guard < 100000) begin
            @(negedge i_clk); guard++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_keep(logic v);
        drain_wait();
        i_cfg_we <= 1; i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        keep_cmt = v;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_rec_kind, o_token_kind, o_line_number, o_line_start_pos,
                   o_start_pos, o_token_length, o_error_code, o_last_result};
            if (tok_queue.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected item %h", got);
            end else begin
                exp_r = tok_queue.pop_front();
                if (got.rec_kind) n_status++; else n_tok++;
                if (got !== exp_r) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("mismatch: exp kind %0d tk %0d ln %0d ls %0d sp %0d len %0d e %0d",
                            exp_r.rec_kind, exp_r.token_kind, exp_r.line_number,
                            exp_r.line_start_pos, exp_r.start_pos, exp_r.token_length,
                            exp_r.error_code);
                        $display("          got kind %0d tk %0d ln %0d ls %0d sp %0d len %0d e %0d",
                            got.rec_kind, got.token_kind, got.line_number,
                            got.line_start_pos, got.start_pos, got.token_length,
                            got.error_code);
                    end
                end
            end
        end
    end

    // Drive receiver stall at the falling edge
    always @(negedge i_clk) begin
        if (out_random) i_stall <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
        else i_stall <= 1'b0;
    end

    task automatic test_directed();
        write_keep(1);
        send_text("#!sh x\nab(1,2)[]{}\n", 1);
        send_text("// note\n'a\\'b' \"s\" x/y\n", 1);
        send_text(")x(", 1);
        send_text("{[\n(", 1);
        send_text("a\"bad\nzz", 1);
        send_byte(8'hFF, 0); send_byte(8'h00, 0); send_byte("/", 1);
        write_keep(0);
        send_text("//c\n}a ]", 1);
        send_text("\"open", 1);
    endtask

    function automatic logic [7:0] pick_char();
        string pool;
        pool = "abz09_ +-/*#!=<>;:.(){}[],\"'\\\t\n";
        if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic test_random();
        int sent, len;
        sent = 0;
        while (sent < 355) begin
            if (sent > 200 && sent < 215) write_keep(1'($urandom_range(0, 1)));
            len = $urandom_range(1, 30);
            for (int k = 0; k < len; k++) begin
                send_byte(pick_char(), k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_wdata = 0; i_valid = 0;
        i_src_byte = '0; i_is_last = 0; i_stall = 0; out_random = 0;
        n_fail = 0; n_tok = 0; n_status = 0; keep_cmt = 0;
        clear_stream();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        out_random = 1;
        test_directed();
        test_random();
        write_keep(1);
        drain_wait();
        if (tok_queue.size() != 0) n_fail++;
        $display("checked %0d tokens and %0d status items", n_tok, n_status);
        if (n_fail == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
